// ===== design/wpa_pkg.sv =====
// Shared types and constants for the worker pool affinity allocator.
// Used by the front stage, the command queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wpa_pkg;

  // Pool geometry
  localparam int MaxWorkers = 16;
  localparam int SlotW      = 4;   // bits of a worker index
  localparam int CntW       = 5;   // bits of a count that can reach MaxWorkers
  localparam int TagW       = 16;
  localparam int QDepth     = 2;   // command queue entries
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  // Configuration
  localparam int          DataW    = 32;
  localparam int          AddrW    = 3;
  localparam logic        RegLimit = 1'b0;   // register index 0: pool_limit
  localparam logic [CntW-1:0] LimitRst = 5'd16;

  typedef enum logic {
    KIND_REQ = 1'b0,
    KIND_UPD = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_NEW     = 3'd1,
    ST_OTHER   = 3'd2,
    ST_RETRY   = 3'd3,
    ST_UPDATED = 3'd4,
    ST_BAD     = 3'd5
  } status_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_SCAN = 1'b1
  } back_state_e;

  // Input word as it arrives on the ports
  typedef struct packed {
    logic             kind;
    logic [TagW-1:0]  tag_first;
    logic [TagW-1:0]  tag_second;
    logic [SlotW-1:0] worker_slot;
    logic             mark_busy;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [SlotW-1:0] granted_slot;
    logic [2:0]       status;
    logic [CntW-1:0]  free_workers;
  } out_word_t;

  // Classified command carried through the queue
  typedef struct packed {
    kind_e            op;
    logic [TagW-1:0]  tag_first;
    logic [TagW-1:0]  tag_second;
    logic [SlotW-1:0] slot;
    logic             mark;
  } cmd_t;

  // Pool status reported by the back end
  typedef struct packed {
    logic [CntW-1:0] created;
    logic [CntW-1:0] free_cnt;
  } pool_stat_t;

endpackage

`default_nettype wire

// ===== design/wpa_front.sv =====
// Front stage: takes a word on start, decodes its kind and holds it until
// the command queue has room. Depends on wpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpa_front
  import wpa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_word_t item_i,
  input  wire logic     q_full_i,
  output logic          busy_o,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic stage_v_q, stage_v_d;
  cmd_t stage_q;
  logic accept;

  assign accept = start_i & ~stage_v_q;
  assign push_o = stage_v_q & ~q_full_i;
  assign busy_o = stage_v_q;
  assign cmd_o  = stage_q;

  // stage occupancy
  always_comb begin
    stage_v_d = stage_v_q;
    if (accept) begin
      stage_v_d = 1'b1;
    end else if (push_o) begin
      stage_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  // classify and capture the word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.op         <= kind_e'(item_i.kind);
      stage_q.tag_first  <= item_i.tag_first;
      stage_q.tag_second <= item_i.tag_second;
      stage_q.slot       <= item_i.worker_slot;
      stage_q.mark       <= item_i.mark_busy;
    end
  end

endmodule

`default_nettype wire

// ===== design/wpa_queue.sv =====
// Two-entry command queue between the front stage and the back end.
// Depends on wpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpa_queue
  import wpa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/wpa_back.sv =====
// Back end: executes updates and scans the worker table for requests,
// one entry per cycle through the tag memory. Depends on wpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpa_back
  import wpa_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire cmd_t            head_i,
  input  wire logic [CntW-1:0] pool_limit_i,
  output logic                 pop_o,
  output logic                 done_o,
  output out_word_t            result_o,
  output pool_stat_t           stat_o
);

  back_state_e state_q, state_d;

  logic [MaxWorkers-1:0] busy_q, busy_d;
  logic [CntW-1:0]       created_q, created_d;
  logic [CntW-1:0]       free_q, free_d;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic                  chk_v_q, chk_v_d;
  logic [SlotW-1:0]      chk_idx_q, chk_idx_d;
  logic                  ff_v_q, ff_v_d;
  logic [SlotW-1:0]      ff_idx_q, ff_idx_d;
  logic                  done_q, done_d;
  out_word_t             res_q, res_d;
  cmd_t                  cmd_q, cmd_d;

  // tag memory: {tag_second, tag_first} per worker
  logic [2*TagW-1:0]     tag_mem [MaxWorkers];
  logic [2*TagW-1:0]     rd_q;
  logic [SlotW-1:0]      rd_addr;
  logic                  mem_we;

  logic [CntW-1:0]       limit;
  logic                  issue, chk_free, hit;

  assign limit = (pool_limit_i > CntW'(MaxWorkers)) ? CntW'(MaxWorkers) : pool_limit_i;

  assign issue    = (state_q == B_SCAN) && (ptr_q < created_q);
  assign rd_addr  = ptr_q[SlotW-1:0];
  assign chk_free = chk_v_q && !busy_q[chk_idx_q];
  assign hit      = chk_free && (rd_q == {cmd_q.tag_second, cmd_q.tag_first});

  // sequencer: next state and result
  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    created_d = created_q;
    free_d    = free_q;
    ptr_d     = ptr_q;
    chk_v_d   = 1'b0;
    chk_idx_d = chk_idx_q;
    ff_v_d    = ff_v_q;
    ff_idx_d  = ff_idx_q;
    done_d    = 1'b0;
    res_d     = res_q;
    cmd_d     = cmd_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.op == KIND_UPD) begin
            done_d = 1'b1;
            if ({1'b0, head_i.slot} < created_q) begin
              busy_d[head_i.slot] = head_i.mark;
              mem_we              = 1'b1;
              if (busy_q[head_i.slot] && !head_i.mark) begin
                free_d = free_q + 1'b1;
              end else if (!busy_q[head_i.slot] && head_i.mark) begin
                free_d = free_q - 1'b1;
              end
              res_d = '{granted_slot: head_i.slot, status: ST_UPDATED, free_workers: free_d};
            end else begin
              res_d = '{granted_slot: '0, status: ST_BAD, free_workers: free_q};
            end
          end else begin
            cmd_d   = head_i;
            ptr_d   = '0;
            ff_v_d  = 1'b0;
            state_d = B_SCAN;
          end
        end
      end

      B_SCAN: begin
        // read one entry, check the one read last cycle
        if (issue) begin
          ptr_d     = ptr_q + 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = ptr_q[SlotW-1:0];
        end
        if (chk_free && !ff_v_q) begin
          ff_v_d   = 1'b1;
          ff_idx_d = chk_idx_q;
        end

        if (hit) begin
          busy_d[chk_idx_q] = 1'b1;
          free_d  = free_q - 1'b1;
          res_d   = '{granted_slot: chk_idx_q, status: ST_MATCH, free_workers: free_d};
          done_d  = 1'b1;
          chk_v_d = 1'b0;
          state_d = B_IDLE;
        end else if (!issue && !chk_v_q) begin
          // every created worker checked without a match
          done_d  = 1'b1;
          state_d = B_IDLE;
          if (created_q < limit) begin
            busy_d[created_q[SlotW-1:0]] = 1'b1;
            created_d = created_q + 1'b1;
            res_d = '{granted_slot: created_q[SlotW-1:0], status: ST_NEW,
                      free_workers: free_q};
          end else if (ff_v_q) begin
            busy_d[ff_idx_q] = 1'b1;
            free_d = free_q - 1'b1;
            res_d  = '{granted_slot: ff_idx_q, status: ST_OTHER, free_workers: free_d};
          end else begin
            res_d = '{granted_slot: '0, status: ST_RETRY, free_workers: free_q};
          end
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      busy_q    <= '0;
      created_q <= '0;
      free_q    <= '0;
      ptr_q     <= '0;
      chk_v_q   <= 1'b0;
      ff_v_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      busy_q    <= busy_d;
      created_q <= created_d;
      free_q    <= free_d;
      ptr_q     <= ptr_d;
      chk_v_q   <= chk_v_d;
      ff_v_q    <= ff_v_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    ff_idx_q  <= ff_idx_d;
    res_q     <= res_d;
    cmd_q     <= cmd_d;
  end

  // tag memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[head_i.slot] <= {head_i.tag_second, head_i.tag_first};
    end
    rd_q <= tag_mem[rd_addr];
  end

  assign done_o   = done_q;
  assign result_o = res_q;
  assign stat_o   = '{created: created_q, free_cnt: free_q};

endmodule

`default_nettype wire

// ===== design/worker_pool_affinity_allocator_core.sv =====
// Throughput: one word at a time in the back end, whose table scan reads one
// tag memory entry per cycle; the front stage and queue take new words meanwhile.
// Reset: busy flags clear, no workers created, pool_limit 16; the tag memory
// is not cleared and needs no clearing pass. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module worker_pool_affinity_allocator_core
  import wpa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // command port
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         item_i,
  output logic                  done_o,
  output out_word_t             result_o,
  // configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  logic            q_full, q_empty, push, pop;
  cmd_t            push_cmd, head_cmd;
  pool_stat_t      stat;
  logic [CntW-1:0] pool_limit_q;
  logic            reg_idx;
  logic            cfg_wr;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_limit_q <= LimitRst;
    end else if (cfg_wr && (reg_idx == RegLimit)) begin
      pool_limit_q <= pwdata[CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegLimit) begin
      prdata = DataW'(pool_limit_q);
    end
  end

  wpa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (item_i),
    .q_full_i (q_full),
    .busy_o   (busy),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  wpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  wpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head_cmd),
    .pool_limit_i (pool_limit_q),
    .pop_o        (pop),
    .done_o       (done_o),
    .result_o     (result_o),
    .stat_o       (stat)
  );

`ifndef ASSERT_OFF
  // free workers are always a subset of created ones
  a_free_le_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.free_cnt <= stat.created) && (stat.created <= CntW'(MaxWorkers)))
    else $error("free count exceeds created workers");

  // the front stage never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full command queue");

  // reported free count matches the pool state after the step
  a_free_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.free_workers == stat.free_cnt))
    else $error("result free count disagrees with pool state");

  // retry and bad index never name a worker
  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((result_o.status == ST_RETRY) || (result_o.status == ST_BAD)))
      |-> (result_o.granted_slot == '0))
    else $error("worker named on retry or bad index");
`endif

endmodule

`default_nettype wire

// ===== test/worker_pool_affinity_allocator_core_tb.sv =====
// Self-checking testbench for worker_pool_affinity_allocator_core.
// Drives command words and pool_limit writes and checks every result word against an
// in-bench model of the pool. Depends on wpa_pkg and the core RTL only.
`timescale 1ns / 1ps

module worker_pool_affinity_allocator_core_tb;
  import wpa_pkg::*;

  typedef struct {
    in_word_t word;
    bit       hold_for_drain;  // launch only once every result is back
  } pending_t;

  localparam logic [AddrW-1:0] LimitAddr = AddrW'(4 * int'(RegLimit));
  localparam int NumPhases = 6;
  localparam int PhaseLimit [NumPhases] = '{5, 9, 31, 16, 1, 0};
  localparam int PhaseIdle  [NumPhases] = '{0, 58, 0, 31, 58, 0};
  localparam int PhaseLen   [NumPhases] = '{150, 200, 250, 250, 150, 100};

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start   = 1'b0;
  logic             busy;
  in_word_t         item_i  = '0;
  logic             done_o;
  out_word_t        result_o;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Command words waiting to launch and result words still owed by the core
  pending_t  dispatch_q[$];
  out_word_t grant_q[$];

  // Pool model
  logic [MaxWorkers-1:0] pool_busy = '0;
  logic [TagW-1:0]       pool_tag_lo [MaxWorkers];
  logic [TagW-1:0]       pool_tag_hi [MaxWorkers];
  int                    pool_created = 0;
  int                    pool_limit_m = int'(LimitRst);

  int        errors = 0;
  int        words_done = 0;
  int        status_tally [8];
  int        sender_idle_pct = 0;
  bit        calm = 1'b0;
  logic [TagW-1:0] tag_palette [4];

  worker_pool_affinity_allocator_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial forever #10 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("ERROR %0t: %s got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // Grant or update against the pool; returns the word the core must answer
  function automatic out_word_t allocate_or_update(in_word_t w);
    out_word_t r;
    bit        hit;
    int        eff_limit;
    int        nfree;
    int        i;
    r.granted_slot = '0;
    r.status       = ST_RETRY;
    hit            = 1'b0;
    nfree          = 0;
    eff_limit      = (pool_limit_m > MaxWorkers) ? MaxWorkers : pool_limit_m;
    if (w.kind == KIND_UPD) begin
      if (int'(w.worker_slot) < pool_created) begin
        pool_busy[w.worker_slot]   = w.mark_busy;
        pool_tag_lo[w.worker_slot] = w.tag_first;
        pool_tag_hi[w.worker_slot] = w.tag_second;
        r.granted_slot = w.worker_slot;
        r.status       = ST_UPDATED;
      end else begin
        r.status = ST_BAD;
      end
    end else begin
      // affinity: lowest free worker holding both tags
      for (i = 0; i < pool_created && !hit; i++) begin
        if (!pool_busy[i] && pool_tag_lo[i] == w.tag_first && pool_tag_hi[i] == w.tag_second) begin
          pool_busy[i]   = 1'b1;
          r.granted_slot = SlotW'(i);
          r.status       = ST_MATCH;
          hit            = 1'b1;
        end
      end
      // grow the pool while below the limit
      if (!hit && pool_created < eff_limit) begin
        pool_busy[pool_created] = 1'b1;
        r.granted_slot = SlotW'(pool_created);
        r.status       = ST_NEW;
        pool_created++;
        hit = 1'b1;
      end
      // fall back to any free worker
      for (i = 0; i < pool_created && !hit; i++) begin
        if (!pool_busy[i]) begin
          pool_busy[i]   = 1'b1;
          r.granted_slot = SlotW'(i);
          r.status       = ST_OTHER;
          hit            = 1'b1;
        end
      end
    end
    for (i = 0; i < pool_created; i++)
      if (!pool_busy[i]) nfree++;
    r.free_workers = CntW'(nfree);
    status_tally[r.status]++;
    return r;
  endfunction

  function automatic void queue_word(kind_e k, logic [TagW-1:0] t1, logic [TagW-1:0] t2,
                                     logic [SlotW-1:0] s, logic m, bit hold);
    pending_t p;
    p.word.kind        = k;
    p.word.tag_first   = t1;
    p.word.tag_second  = t2;
    p.word.worker_slot = s;
    p.word.mark_busy   = m;
    p.hold_for_drain   = hold;
    dispatch_q.insert(dispatch_q.size(), p);
  endfunction

  // Mostly palette tags so that affinity hits happen, sometimes any value
  function automatic logic [TagW-1:0] pick_tag();
    if ($urandom_range(0, 9) < 7) return tag_palette[$urandom_range(0, 3)];
    return TagW'($urandom);
  endfunction

  function automatic void queue_random_word();
    kind_e k;
    k = ($urandom_range(0, 99) < 50) ? KIND_REQ : KIND_UPD;
    queue_word(k, pick_tag(), pick_tag(), SlotW'($urandom_range(0, MaxWorkers - 1)),
               ($urandom_range(0, 99) < 25), ($urandom_range(0, 59) == 0));
  endfunction

  // Write pool_limit, then read it back
  task automatic program_pool_limit(logic [CntW-1:0] lim);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LimitAddr;
    pwdata  <= DataW'(lim);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== DataW'(lim)) report_mismatch("pool_limit readback", prdata, lim);
    psel    <= 1'b0;
    penable <= 1'b0;
    pool_limit_m = int'(lim);
  endtask

  // Wait until the core owes nothing, then cover the longest scan
  task automatic settle();
    while (dispatch_q.size() != 0 || grant_q.size() != 0 || start || busy)
      @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // Driver: hold start until the word is taken, then maybe idle
  always @(posedge clk_i) begin
    logic launch;
    if (rst_ni) begin
      launch = start;
      if (start && !busy) begin
        grant_q.insert(grant_q.size(), allocate_or_update(dispatch_q[0].word));
        dispatch_q.delete(0);
        launch = 1'b0;
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (!launch && dispatch_q.size() != 0 &&
          !(dispatch_q[0].hold_for_drain && grant_q.size() != 0) &&
          (calm || $urandom_range(0, 99) >= sender_idle_pct))
        launch = 1'b1;
      start <= launch;
      if (launch) item_i <= dispatch_q[0].word;
    end
  end

  // Monitor: each strobed word against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result word", result_o, 0);
      end else begin
        want = grant_q.pop_front();
        words_done++;
        if (result_o.granted_slot !== want.granted_slot)
          report_mismatch("granted_slot", result_o.granted_slot, want.granted_slot);
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.free_workers !== want.free_workers)
          report_mismatch("free_workers", result_o.free_workers, want.free_workers);
      end
    end
  end

  initial begin
    int p;
    int n;
    tag_palette[0] = '0;
    tag_palette[1] = '1;
    tag_palette[2] = TagW'($urandom);
    tag_palette[3] = TagW'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-worker pool: bad index, creation, retry, other-free, affinity hit
    program_pool_limit(5'd1);
    queue_word(KIND_UPD, 16'h0000, 16'h0000, 4'd0,  1'b0, 1'b0);
    queue_word(KIND_UPD, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1, 1'b0);
    queue_word(KIND_REQ, 16'h0000, 16'h0000, 4'd15, 1'b1, 1'b0);
    queue_word(KIND_REQ, 16'hFFFF, 16'hFFFF, 4'd0,  1'b0, 1'b0);
    queue_word(KIND_UPD, 16'hFFFF, 16'hFFFF, 4'd0,  1'b0, 1'b0);
    queue_word(KIND_REQ, 16'hFFFF, 16'h0000, 4'd0,  1'b0, 1'b0);
    queue_word(KIND_UPD, 16'hFFFF, 16'hFFFF, 4'd0,  1'b0, 1'b0);
    queue_word(KIND_REQ, 16'hFFFF, 16'hFFFF, 4'd0,  1'b0, 1'b1);
    queue_word(KIND_UPD, 16'h1234, 16'h5678, 4'd1,  1'b0, 1'b0);
    // update that marks an already busy worker busy leaves the free count unchanged
    queue_word(KIND_UPD, 16'h1234, 16'h5678, 4'd0,  1'b1, 1'b0);
    settle();

    // Limit zero: no creation, existing workers still served
    program_pool_limit(5'd0);
    queue_word(KIND_REQ, 16'h0000, 16'h0000, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_UPD, 16'hA5A5, 16'h5A5A, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_REQ, 16'h0000, 16'h0000, 4'd0, 1'b0, 1'b0);
    settle();

    // Grow to three, fill up, then two workers sharing tags: lowest wins
    program_pool_limit(5'd3);
    queue_word(KIND_REQ, 16'h0001, 16'h8000, 4'd7, 1'b1, 1'b0);
    queue_word(KIND_REQ, 16'h0001, 16'h8000, 4'd8, 1'b0, 1'b0);
    queue_word(KIND_REQ, 16'h0001, 16'h8000, 4'd0, 1'b0, 1'b0);
    queue_word(KIND_UPD, 16'h8000, 16'h0001, 4'd2, 1'b0, 1'b0);
    queue_word(KIND_UPD, 16'h8000, 16'h0001, 4'd1, 1'b0, 1'b0);
    queue_word(KIND_REQ, 16'h8000, 16'h0001, 4'd0, 1'b0, 1'b0);
    settle();

    // Random phases across limits and sender idle rates
    for (p = 0; p < NumPhases; p++) begin
      program_pool_limit(CntW'(PhaseLimit[p]));
      sender_idle_pct = PhaseIdle[p];
      for (n = 0; n < PhaseLen[p]; n++) queue_random_word();
      settle();
    end

    $display("Covered %0d result words with pool limits 0 to 31 and sender idle 0/31/58 pct",
             words_done);
    $display("  tag hits %0d, new %0d, other %0d, retry %0d, updated %0d, bad index %0d",
             status_tally[ST_MATCH], status_tally[ST_NEW], status_tally[ST_OTHER],
             status_tally[ST_RETRY], status_tally[ST_UPDATED], status_tally[ST_BAD]);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("worker_pool_affinity_allocator_core: match");
    end else begin
      $display("worker_pool_affinity_allocator_core: mismatch");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("ERROR: timeout with %0d result words outstanding", grant_q.size());
    $display("worker_pool_affinity_allocator_core: mismatch");
    $finish;
  end

endmodule
